// ===== sv/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, types and helpers of the 3x3 box blur stream.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int DIM_W  = 11;
  localparam int ROW_W  = 11;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int NUM_W  = SUM_W + 1;
  localparam int RCP_W  = 18;
  localparam int RCP_SH = 20;
  localparam int PROD_W = NUM_W + RCP_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] DIM_MIN   = 11'd2;
  localparam logic [DIM_W-1:0] WIDTH_HI  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_HI = DIM_W'(MAX_HEIGHT);

  // neighborhood flags of one output pixel
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } nbr_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // ceil(2^20 / (2*cnt)); exact floor over the numerator range for cnt 4, 6, 9
  function automatic logic [RCP_W-1:0] recip(input logic [3:0] cnt);
    logic [RCP_W-1:0] m;
    case (cnt)
      4'd4:    m = 18'd131072;
      4'd6:    m = 18'd87382;
      4'd9:    m = 18'd58255;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/box_blur_3x3_stream.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_stream
// Mean of each in-frame 3x3 neighborhood of an RGB raster stream, rounded half up per channel.
// ----------------------------------------------------------------------------
// path: the beat that completes a neighborhood passes the line store read, the
//   sum and the divide into the buffer before its result shows on the master side
// throughput: one beat per cycle; the single line store read-modify-write per
//   beat and the 8-entry output buffer set the rate, s_axis_tready drops only
//   while that buffer plus the 3 pipeline stages hold 8 items or a register
//   write is offered
// reset: counters cleared, frame size 1024 x 1024, line store undefined (no
//   clearing pass, unwritten rows are masked out of the mean)
`default_nettype none

module box_blur_3x3_stream
  import bb3_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
  input  wire logic                 s_axis_tuser,   // op
  // output stream
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [PIX_W-1:0]     m_axis_tdata,   // red_out, green_out, blue_out
  output      logic                 m_axis_tlast    // frame_last
);

  // configuration
  logic [DIM_W-1:0] w_q, w_d, h_q, h_d;

  // position counters
  logic [ADDR_W-1:0] col_q, col_d, ocol_q, ocol_d;
  logic [ROW_W-1:0]  row_q, row_d, orow_q, orow_d;

  // line store: {older row, previous row} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  // stage 1 (read data back, write back, window shift)
  logic              v1_q, v1_d, emit1_q, fwd1_q;
  logic [ADDR_W-1:0] addr1_q;
  logic [PIX_W-1:0]  pix1_q;
  nbr_t              nb1_q, nb1_d;
  logic              emit_d;
  logic [PIX_W-1:0]  older_eff, prev_eff;
  logic [PIX_W-1:0]  fw_older_q, fw_prev_q;

  logic [PIX_W-1:0]  win_q [3][3];

  // stage 2 (sum), stage 3 (divide)
  logic              v2_q, v3_q;
  nbr_t              nb2_q;
  logic              last3_q;
  logic [NUM_W-1:0]  num_d [3];
  logic [NUM_W-1:0]  num3_q [3];
  logic [RCP_W-1:0]  rcp_d, rcp3_q;
  logic [CH_W-1:0]   quo [3];

  // output buffer
  logic [PIX_W:0]    fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]  cnt_q, cnt_d;
  logic [FIFO_AW+1:0] occ;
  logic              push, pop;

  logic              in_acc, act, cfg_wr;
  logic [ADDR_W-1:0] c_eff;
  logic [DIM_W-1:0]  c_next;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  assign occ = {1'b0, cnt_q} + (FIFO_AW+2)'(v1_q) + (FIFO_AW+2)'(v2_q) + (FIFO_AW+2)'(v3_q);
  // a register write takes the cycle, no pixel beat is taken beside it
  assign s_axis_tready = !cfg_valid_i && (occ < (FIFO_AW+2)'(FIFO_DEPTH));
  assign in_acc = s_axis_tvalid && s_axis_tready;
  // drain beat while pixels are still due is dropped
  assign act    = !(s_axis_tuser && (row_q < h_q));

  // ---------------------------------------------------------------- counters
  always_comb begin
    w_d    = w_q;
    h_d    = h_q;
    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    v1_d   = 1'b0;
    emit_d = 1'b0;
    nb1_d  = '0;
    c_eff  = ({1'b0, col_q} >= w_q) ? '0 : col_q;
    c_next = {1'b0, c_eff} + 1'b1;

    nb1_d.top   = (orow_q != '0);
    nb1_d.bot   = ({1'b0, orow_q} + 1'b1) < {1'b0, h_q};
    nb1_d.left  = (ocol_q != '0);
    nb1_d.right = ({1'b0, ocol_q} + 1'b1) < w_q;
    nb1_d.last  = (orow_q == h_q - 1'b1) && ({1'b0, ocol_q} == w_q - 1'b1);

    if (cfg_wr) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        w_d = clamp_dim(cfg_data_i, WIDTH_HI);
      end
      if (cfg_index_i == CFG_FRAME_HEIGHT) begin
        h_d = clamp_dim(cfg_data_i, HEIGHT_HI);
      end
      if (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT) begin
        col_d  = '0;
        row_d  = '0;
        ocol_d = '0;
        orow_d = '0;
      end
    end else if (in_acc && act) begin
      v1_d   = 1'b1;
      emit_d = ((row_q >= 11'd2) || (row_q == 11'd1 && c_eff != '0)) && (orow_q < h_q);
      if (c_next == w_q) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = c_next[ADDR_W-1:0];
      end
      if (emit_d) begin
        if (nb1_d.last) begin
          col_d  = '0;
          row_d  = '0;
          ocol_d = '0;
          orow_d = '0;
        end else if ({1'b0, ocol_q} == w_q - 1'b1) begin
          ocol_d = '0;
          orow_d = orow_q + 1'b1;
        end else begin
          ocol_d = ocol_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WIDTH_HI;
      h_q    <= HEIGHT_HI;
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      w_q    <= w_d;
      h_q    <= h_d;
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      v1_q   <= v1_d;
      v2_q   <= v1_q && emit1_q;
      v3_q   <= v2_q;
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q  <= cnt_d;
    end
  end

  // ------------------------------------------------------------- line store
  assign older_eff = fwd1_q ? fw_older_q : rd_q[2*PIX_W-1:PIX_W];
  assign prev_eff  = fwd1_q ? fw_prev_q  : rd_q[PIX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      line_mem[addr1_q] <= {prev_eff, pix1_q};
    end
    if (v1_d) begin
      rd_q <= line_mem[c_eff];
    end
  end

  // stage 1 payload and window
  always_ff @(posedge clk_i) begin
    if (v1_d) begin
      addr1_q <= c_eff;
      pix1_q  <= s_axis_tdata;
      nb1_q   <= nb1_d;
      emit1_q <= emit_d;
      // same column written by the beat now in stage 1: read data is stale
      fwd1_q  <= v1_q && (addr1_q == c_eff);
    end
    if (v1_q) begin
      fw_older_q <= prev_eff;
      fw_prev_q  <= pix1_q;
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= older_eff;
      win_q[1][2] <= prev_eff;
      win_q[2][2] <= pix1_q;
      nb2_q       <= nb1_q;
    end
  end

  // ------------------------------------------------------------ stage 2 sum
  always_comb begin
    logic [2:0]       rowen, colen;
    logic [1:0]       nrows, ncols;
    logic [3:0]       cnt;
    logic [SUM_W-1:0] sum;
    rowen = {nb2_q.bot, 1'b1, nb2_q.top};
    colen = {nb2_q.right, 1'b1, nb2_q.left};
    nrows = 2'd1 + 2'(nb2_q.top) + 2'(nb2_q.bot);
    ncols = 2'd1 + 2'(nb2_q.left) + 2'(nb2_q.right);
    cnt   = {2'b0, nrows} * {2'b0, ncols};
    rcp_d = recip(cnt);
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (rowen[k] && colen[j]) begin
            sum = sum + {{(SUM_W-CH_W){1'b0}}, win_q[k][j][CH_W*ch +: CH_W]};
          end
        end
      end
      num_d[ch] = {sum, 1'b0} + {{(NUM_W-4){1'b0}}, cnt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      num3_q  <= num_d;
      rcp3_q  <= rcp_d;
      last3_q <= nb2_q.last;
    end
  end

  // --------------------------------------------------------- stage 3 divide
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      prod    = {{RCP_W{1'b0}}, num3_q[ch]} * {{NUM_W{1'b0}}, rcp3_q};
      quo[ch] = prod[RCP_SH +: CH_W];
    end
  end

  // ----------------------------------------------------------- output buffer
  assign push = v3_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= {last3_q, quo[2], quo[1], quo[0]};
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rptr_q][PIX_W-1:0];
  assign m_axis_tlast  = fifo_q[rptr_q][PIX_W];

  // -------------------------------------------------------------- assertions
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
    else $error("output buffer overflow");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH)) |-> !s_axis_tready)
    else $error("input taken with full output buffer");

  a_fwd_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && fwd1_q) |-> $past(v1_q))
    else $error("forwarding without a preceding write");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < w_q) && ({1'b0, ocol_q} < w_q))
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    orow_q < h_q)
    else $error("output row beyond frame height");

endmodule

`default_nettype wire
